// ===== sv/sine_tone_generator_with_duration_unit_defines.svh =====
// ----------------------------------------------------------------------------
// sine tone generator assertion macros
// shared concurrent assertion wrappers, sampled on i_clk
// ----------------------------------------------------------------------------
`ifndef SINE_TONE_GENERATOR_WITH_DURATION_UNIT_DEFINES_SVH
`define SINE_TONE_GENERATOR_WITH_DURATION_UNIT_DEFINES_SVH

// checked only outside reset
`define STG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked through reset as well
`define STG_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/stg_pkg.sv =====
// ----------------------------------------------------------------------------
// stg_pkg
// word types, command codes and constant tables of the sine tone generator
// ----------------------------------------------------------------------------
package stg_pkg;

    // command codes
    localparam logic [1:0] CmdStart = 2'd0;
    localparam logic [1:0] CmdTick  = 2'd1;
    localparam logic [1:0] CmdStop  = 2'd2;

    // duration to tick count conversion
    localparam int ClockHz     = 8000000;
    localparam int TickDivider = 244;
    localparam int Centi       = 100;
    localparam int TickW       = 17;           // 255 units -> 83606 ticks
    localparam int FineW       = 8;
    localparam int CoarseW     = TickW - FineW;
    localparam int PhaseShift  = 7;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] frequency;
        logic [7:0]  duration;
    } t_in_word;

    typedef struct packed {
        logic [7:0] sample;
        logic       tone_on;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic     valid;
        t_in_word word;
    } t_stage;

    typedef logic [TickW-1:0] t_tick_tab [256];

    // tick count per duration code, built at elaboration
    function automatic t_tick_tab f_tick_tab();
        t_tick_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = TickW'(((i * ClockHz) / TickDivider) / Centi);
        end
        return tab;
    endfunction

    localparam t_tick_tab TickTab = f_tick_tab();

    // one full sine period, unsigned with offset 128
    localparam logic [7:0] SineLut [256] = '{
        8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
        8'd152, 8'd155, 8'd158, 8'd162, 8'd165, 8'd167, 8'd170, 8'd173,
        8'd176, 8'd179, 8'd182, 8'd185, 8'd188, 8'd190, 8'd193, 8'd196,
        8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd211, 8'd213, 8'd215,
        8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
        8'd234, 8'd235, 8'd237, 8'd238, 8'd240, 8'd241, 8'd243, 8'd244,
        8'd245, 8'd246, 8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252,
        8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254, 8'd253,
        8'd253, 8'd252, 8'd251, 8'd250, 8'd250, 8'd249, 8'd248, 8'd246,
        8'd245, 8'd244, 8'd243, 8'd241, 8'd240, 8'd238, 8'd237, 8'd235,
        8'd234, 8'd232, 8'd230, 8'd228, 8'd226, 8'd224, 8'd222, 8'd220,
        8'd218, 8'd215, 8'd213, 8'd211, 8'd208, 8'd206, 8'd203, 8'd201,
        8'd198, 8'd196, 8'd193, 8'd190, 8'd188, 8'd185, 8'd182, 8'd179,
        8'd176, 8'd173, 8'd170, 8'd167, 8'd165, 8'd162, 8'd158, 8'd155,
        8'd152, 8'd149, 8'd146, 8'd143, 8'd140, 8'd137, 8'd134, 8'd131,
        8'd128, 8'd124, 8'd121, 8'd118, 8'd115, 8'd112, 8'd109, 8'd106,
        8'd103, 8'd100, 8'd97,  8'd93,  8'd90,  8'd88,  8'd85,  8'd82,
        8'd79,  8'd76,  8'd73,  8'd70,  8'd67,  8'd65,  8'd62,  8'd59,
        8'd57,  8'd54,  8'd52,  8'd49,  8'd47,  8'd44,  8'd42,  8'd40,
        8'd37,  8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd23,
        8'd21,  8'd20,  8'd18,  8'd17,  8'd15,  8'd14,  8'd12,  8'd11,
        8'd10,  8'd9,   8'd7,   8'd6,   8'd5,   8'd5,   8'd4,   8'd3,
        8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,
        8'd2,   8'd3,   8'd4,   8'd5,   8'd5,   8'd6,   8'd7,   8'd9,
        8'd10,  8'd11,  8'd12,  8'd14,  8'd15,  8'd17,  8'd18,  8'd20,
        8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,
        8'd37,  8'd40,  8'd42,  8'd44,  8'd47,  8'd49,  8'd52,  8'd54,
        8'd57,  8'd59,  8'd62,  8'd65,  8'd67,  8'd70,  8'd73,  8'd76,
        8'd79,  8'd82,  8'd85,  8'd88,  8'd90,  8'd93,  8'd97,  8'd100,
        8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124
    };

endpackage

// ===== sv/stg_in_stage.sv =====
// ----------------------------------------------------------------------------
// stg_in_stage
// input register: captures one command word, releases it to the core
// ----------------------------------------------------------------------------
module stg_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  stg_pkg::t_in_word i_in_word,
    input  logic              i_adv,
    output stg_pkg::t_stage   o_stage
);

    logic              r_valid;
    stg_pkg::t_in_word r_word;
    logic              accept;

    assign o_in_stall = r_valid && !i_adv;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= i_in_word;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.word  = r_word;

endmodule

// ===== sv/stg_tone_core.sv =====
// ----------------------------------------------------------------------------
// stg_tone_core
// phase accumulator, duration countdown and output word register
// ----------------------------------------------------------------------------
module stg_tone_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stg_pkg::t_stage    i_stage,
    output logic               o_adv,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output stg_pkg::t_out_word o_out_word
);

    logic [15:0]                 r_phase, n_phase;
    logic [15:0]                 r_step, n_step;
    logic [stg_pkg::FineW-1:0]   r_fine, n_fine;
    logic [stg_pkg::CoarseW-1:0] r_coarse, n_coarse;
    logic                        r_playing, n_playing;
    logic                        r_out_valid;
    stg_pkg::t_out_word          r_out_word, n_out_word;
    logic                        fire, emit;
    logic [stg_pkg::TickW-1:0]   ticks;
    logic [stg_pkg::FineW-1:0]   fine_dec;

    assign o_adv    = !r_out_valid || !i_out_stall;
    assign fire     = i_stage.valid && o_adv;
    assign ticks    = stg_pkg::TickTab[i_stage.word.duration];
    assign fine_dec = r_fine - 1'b1;

    always_comb begin
        n_phase    = r_phase;
        n_step     = r_step;
        n_fine     = r_fine;
        n_coarse   = r_coarse;
        n_playing  = r_playing;
        emit       = 1'b0;
        n_out_word.sample  = stg_pkg::SineLut[r_phase[stg_pkg::PhaseShift +: 8]];
        n_out_word.tone_on = (r_step != 16'd0);
        n_out_word.last    = 1'b0;
        if (fire) begin
            case (i_stage.word.cmd)
                stg_pkg::CmdStart: begin
                    if (i_stage.word.duration != 8'd0) begin
                        n_step    = i_stage.word.frequency;
                        n_fine    = ticks[stg_pkg::FineW-1:0];
                        n_coarse  = ticks[stg_pkg::TickW-1:stg_pkg::FineW];
                        n_playing = 1'b1;
                    end
                end
                stg_pkg::CmdTick: begin
                    if (r_playing) begin
                        emit    = 1'b1;
                        n_phase = r_phase + r_step;
                        n_fine  = fine_dec;
                        if (fine_dec == '0) begin
                            if (r_coarse != '0) begin
                                n_coarse = r_coarse - 1'b1;
                            end else begin
                                n_playing       = 1'b0;
                                n_out_word.last = 1'b1;
                            end
                        end
                    end
                end
                stg_pkg::CmdStop: begin
                    n_playing = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_step      <= '0;
            r_fine      <= '0;
            r_coarse    <= '0;
            r_playing   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_step    <= n_step;
            r_fine    <= n_fine;
            r_coarse  <= n_coarse;
            r_playing <= n_playing;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== sv/sine_tone_generator_with_duration_unit.sv =====
// ----------------------------------------------------------------------------
// sine_tone_generator_with_duration_unit
// dds note player: 16-bit phase accumulator, 8-bit sine table, note timer
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+------------------------------
//  in      | input     | i_in_valid/o_in_stall  | cmd, frequency, duration
//  out     | output    | o_out_valid/i_out_stall| sample, tone_on, last
//
//  one word accepted per cycle while o_in_stall is low; a tick word is
//  registered in the input register and, once the core can advance, its
//  sample word is registered in the output register, where it waits to be taken
//  throughput is set by the single output register: a stalled output word
//  holds the core, and the input register then raises o_in_stall
//  start and stop words update the note state and give no output word
//  i_rst_n is synchronous, active low; it clears phase, step, counts and
//  both valid flags
// ----------------------------------------------------------------------------
module sine_tone_generator_with_duration_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  stg_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output stg_pkg::t_out_word o_out_word
);

    // input register contents handed to the core
    stg_pkg::t_stage stage;
    // core can take the staged word this cycle
    logic            adv;

    // input register stage
    stg_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_adv      (adv),
        .o_stage    (stage)
    );

    // note state, sine lookup, countdown and output register
    stg_tone_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stage     (stage),
        .o_adv       (adv),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== sv/stg_checker.sv =====
// ----------------------------------------------------------------------------
// stg_checker
// port-level checks of the sine tone generator, bound to the top level
// ----------------------------------------------------------------------------
`include "sine_tone_generator_with_duration_unit_defines.svh"

module stg_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input stg_pkg::t_in_word  i_in_word,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input stg_pkg::t_out_word o_out_word
);

    `STG_ASSERT(a_in_hold, i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_word), "in word changed")
    `STG_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "out word dropped")
    `STG_ASSERT(a_out_stable, o_out_valid && i_out_stall |=> $stable(o_out_word), "out word changed")
    `STG_ASSERT(a_stall_cause, o_in_stall |-> o_out_valid && i_out_stall, "input stalled")
    `STG_ASSERT_RST(a_reset_empty, !$past(i_rst_n) |-> !o_out_valid, "output valid after reset")

endmodule

bind sine_tone_generator_with_duration_unit stg_checker u_stg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
